// ===== rtl/core/ttct_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ttct_pkg
// Constants and month tables for the tick to calendar converter.
// ---------------------------------------------------------------------------
package ttct_pkg;

	localparam logic [25:0] TICKS_PER_SEC = 26'd40500000;
	localparam logic [25:0] TICKS_PER_MS  = 26'd40500;
	localparam logic [25:0] TICKS8_PER_US = 26'd324;
	localparam logic [25:0] SECS_PER_DAY  = 26'd86400;
	localparam logic [25:0] SECS_PER_HOUR = 26'd3600;
	localparam logic [25:0] SECS_PER_MIN  = 26'd60;
	localparam logic [25:0] DAYS_PER_WEEK = 26'd7;
	localparam logic [25:0] DAYS_PER_YEAR = 26'd365;
	localparam logic [25:0] CENTURY       = 26'd100;
	localparam logic [25:0] GREG_CYCLE    = 26'd400;
	localparam logic [25:0] THOUSAND      = 26'd1000;
	localparam logic [63:0] MIN_TICKS     = 64'hDC86_DCAA_E185_9000; // -2556113112000000000

	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
		logic [8:0] v;
		case (m)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = leap ? 9'd60  : 9'd59;
			4'd3:    v = leap ? 9'd91  : 9'd90;
			4'd4:    v = leap ? 9'd121 : 9'd120;
			4'd5:    v = leap ? 9'd152 : 9'd151;
			4'd6:    v = leap ? 9'd182 : 9'd181;
			4'd7:    v = leap ? 9'd213 : 9'd212;
			4'd8:    v = leap ? 9'd244 : 9'd243;
			4'd9:    v = leap ? 9'd274 : 9'd273;
			4'd10:   v = leap ? 9'd305 : 9'd304;
			4'd11:   v = leap ? 9'd335 : 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ticks_to_calendar_time.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ticks_to_calendar_time
// The conversion runs on the shared
// bit-serial restoring divider (one quotient bit per cycle) and the
// year and month search steps. One item at a time: busy is high meanwhile.
// done strobes one cycle with the result; the receiver cannot stall.
// arst_n clears the sequencer and done asynchronously.
// ---------------------------------------------------------------------------
module ticks_to_calendar_time (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] tick_count,
	output logic             done,
	output logic [5:0]       second,
	output logic [5:0]       minute,
	output logic [4:0]       hour,
	output logic [4:0]       month_day,
	output logic [3:0]       month,
	output logic [13:0]      year,
	output logic [2:0]       week_day,
	output logic [8:0]       year_day,
	output logic [9:0]       millisecond,
	output logic [9:0]       microsecond
);
	import ttct_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DIV, S_T_DONE, S_MS_DONE, S_US1_DONE, S_US2_DONE, S_SEC_DONE,
		S_HR_DONE, S_MIN_DONE, S_WD_DONE, S_Y0_DONE, S_YCHK, S_YB_DONE, S_YC_DONE,
		S_LEAP, S_L100_DONE, S_L400_DONE, S_MONTH
	} state_t;

	state_t      state_q, ret_q;
	logic [63:0] num_q;
	logic [25:0] rem_q, den_q;
	logic [6:0]  cnt_q;
	logic [38:0] secs_q;
	logic [25:0] frac_q;
	logic [21:0] day_q;
	logic [13:0] year_q, b_q;
	logic [8:0]  yday_q;
	logic [3:0]  month_q;
	logic        leap_q, c100_q;

	logic [63:0] tp;
	logic [27:0] diff;
	logic        ge;
	logic [22:0] ystart;
	logic [13:0] ym1;
	logic [8:0]  mstart;

	function automatic logic [63:0] align(input logic [63:0] v, input logic [6:0] n);
		return v << (7'd64 - n);
	endfunction

	assign tp     = ($signed(tick_count) < $signed(MIN_TICKS)) ? 64'd0 : tick_count - MIN_TICKS;
	assign diff   = {1'b0, rem_q, num_q[63]} - {2'b00, den_q};
	assign ge     = !diff[27];
	assign ym1    = year_q - 14'd1;
	assign ystart = 23'(year_q) * 23'd365 + 23'((15'(year_q) + 15'd3) >> 2) - 23'(b_q)
		+ 23'(num_q[13:0]);
	assign mstart = month_start(leap_q, month_q);
	assign busy   = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						num_q   <= tp;
						rem_q   <= '0;
						den_q   <= TICKS_PER_SEC;
						cnt_q   <= 7'd64;
						ret_q   <= S_T_DONE;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					num_q <= {num_q[62:0], ge};
					rem_q <= ge ? diff[25:0] : {rem_q[24:0], num_q[63]};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) state_q <= ret_q;
				end
				S_T_DONE: begin
					secs_q  <= num_q[38:0];
					frac_q  <= rem_q;
					num_q   <= align(64'(rem_q), 7'd26);
					rem_q   <= '0;
					den_q   <= TICKS_PER_MS;
					cnt_q   <= 7'd26;
					ret_q   <= S_MS_DONE;
					state_q <= S_DIV;
				end
				S_MS_DONE: begin
					millisecond <= num_q[9:0];
					num_q   <= align({35'd0, frac_q, 3'd0}, 7'd29);
					rem_q   <= '0;
					den_q   <= TICKS8_PER_US;
					cnt_q   <= 7'd29;
					ret_q   <= S_US1_DONE;
					state_q <= S_DIV;
				end
				S_US1_DONE: begin
					num_q   <= align(64'(num_q[19:0]), 7'd20);
					rem_q   <= '0;
					den_q   <= THOUSAND;
					cnt_q   <= 7'd20;
					ret_q   <= S_US2_DONE;
					state_q <= S_DIV;
				end
				S_US2_DONE: begin
					microsecond <= rem_q[9:0];
					num_q   <= align(64'(secs_q), 7'd39);
					rem_q   <= '0;
					den_q   <= SECS_PER_DAY;
					cnt_q   <= 7'd39;
					ret_q   <= S_SEC_DONE;
					state_q <= S_DIV;
				end
				S_SEC_DONE: begin
					day_q   <= num_q[21:0];
					num_q   <= align(64'(rem_q[16:0]), 7'd17);
					rem_q   <= '0;
					den_q   <= SECS_PER_HOUR;
					cnt_q   <= 7'd17;
					ret_q   <= S_HR_DONE;
					state_q <= S_DIV;
				end
				S_HR_DONE: begin
					hour    <= num_q[4:0];
					num_q   <= align(64'(rem_q[11:0]), 7'd12);
					rem_q   <= '0;
					den_q   <= SECS_PER_MIN;
					cnt_q   <= 7'd12;
					ret_q   <= S_MIN_DONE;
					state_q <= S_DIV;
				end
				S_MIN_DONE: begin
					minute  <= num_q[5:0];
					second  <= rem_q[5:0];
					num_q   <= align(64'(23'(day_q) + 23'd6), 7'd23);
					rem_q   <= '0;
					den_q   <= DAYS_PER_WEEK;
					cnt_q   <= 7'd23;
					ret_q   <= S_WD_DONE;
					state_q <= S_DIV;
				end
				S_WD_DONE: begin
					week_day <= rem_q[2:0];
					num_q   <= align(64'(day_q), 7'd22);
					rem_q   <= '0;
					den_q   <= DAYS_PER_YEAR;
					cnt_q   <= 7'd22;
					ret_q   <= S_Y0_DONE;
					state_q <= S_DIV;
				end
				S_Y0_DONE: begin
					year_q  <= num_q[13:0];
					state_q <= S_YCHK;
				end
				S_YCHK: begin
					if (year_q == 14'd0) begin
						yday_q  <= day_q[8:0];
						state_q <= S_LEAP;
					end else begin
						num_q   <= align(64'(ym1), 7'd14);
						rem_q   <= '0;
						den_q   <= CENTURY;
						cnt_q   <= 7'd14;
						ret_q   <= S_YB_DONE;
						state_q <= S_DIV;
					end
				end
				S_YB_DONE: begin
					b_q     <= num_q[13:0];
					num_q   <= align(64'(ym1), 7'd14);
					rem_q   <= '0;
					den_q   <= GREG_CYCLE;
					cnt_q   <= 7'd14;
					ret_q   <= S_YC_DONE;
					state_q <= S_DIV;
				end
				S_YC_DONE: begin
					if (23'(day_q) >= ystart) begin
						yday_q  <= 9'(23'(day_q) - ystart);
						state_q <= S_LEAP;
					end else begin
						year_q  <= ym1;
						state_q <= S_YCHK;
					end
				end
				S_LEAP: begin
					num_q   <= align(64'(year_q), 7'd14);
					rem_q   <= '0;
					den_q   <= CENTURY;
					cnt_q   <= 7'd14;
					ret_q   <= S_L100_DONE;
					state_q <= S_DIV;
				end
				S_L100_DONE: begin
					c100_q  <= (rem_q == 26'd0);
					num_q   <= align(64'(year_q), 7'd14);
					rem_q   <= '0;
					den_q   <= GREG_CYCLE;
					cnt_q   <= 7'd14;
					ret_q   <= S_L400_DONE;
					state_q <= S_DIV;
				end
				S_L400_DONE: begin
					leap_q  <= ((year_q[1:0] == 2'd0) && !c100_q) || (rem_q == 26'd0);
					month_q <= 4'd11;
					state_q <= S_MONTH;
				end
				S_MONTH: begin
					if (month_q != 4'd0 && yday_q < mstart) begin
						month_q <= month_q - 4'd1;
					end else begin
						month_day <= 5'(yday_q - mstart + 9'd1);
						month     <= month_q;
						year      <= year_q;
						year_day  <= yday_q;
						done      <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_ticks_to_calendar_time.sv =====
// ---------------------------------------------------------------------------
// tb_ticks_to_calendar_time
// Self-checking bench for the tick to calendar converter. Tick counts go in
// through the start/busy handshake with random gaps, except for a gap-free run
// in the random test. Every accepted tick count is turned into its expected
// calendar record by a model inside the bench. Each done strobe is compared
// field by field with the oldest expected record.
// ---------------------------------------------------------------------------
module tb_ticks_to_calendar_time;
	timeunit 1ns;
	timeprecision 1ps;
	import ttct_pkg::*;

	localparam longint TICK_HZ    = 64'd40500000;
	localparam longint DAY_SECS   = 64'd86400;
	localparam longint EPOCH_DAYS = 64'd730485; // day number of 2000-01-01
	localparam int     CYCLE_LIMIT = 3000000;
	localparam int     CUM_COMMON [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	localparam int     CUM_LEAP   [12] = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  month_day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [2:0]  week_day;
		logic [8:0]  year_day;
		logic [9:0]  millisecond;
		logic [9:0]  microsecond;
	} cal_rec_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] tick_count;
	logic        done;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [4:0]  month_day;
	logic [3:0]  month;
	logic [13:0] year;
	logic [2:0]  week_day;
	logic [8:0]  year_day;
	logic [9:0]  millisecond;
	logic [9:0]  microsecond;

	cal_rec_t pending_dates[$];
	int       n_errors;
	int       n_sent;
	int       n_checked;
	int       n_cycles;
	bit       no_gaps;

	ticks_to_calendar_time uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .tick_count(tick_count),
		.done(done), .second(second), .minute(minute), .hour(hour), .month_day(month_day),
		.month(month), .year(year), .week_day(week_day), .year_day(year_day),
		.millisecond(millisecond), .microsecond(microsecond)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint leap_days_upto(longint y);
		if (y < 1)
			return 0;
		return (y + 3) / 4 - (y - 1) / 100 + (y - 1) / 400;
	endfunction

	function automatic bit is_leap(longint y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic cal_rec_t predict_calendar(logic [63:0] raw);
		cal_rec_t r;
		longint t, fr, secs, d, sod, y, ys, yd;
		int m;
		bit lp;
		t = signed'(raw);
		if (t < signed'(MIN_TICKS))
			t = signed'(MIN_TICKS);
		fr = t % TICK_HZ;
		if (fr < 0)
			fr += TICK_HZ;
		secs = (t - fr) / TICK_HZ;
		d = secs / DAY_SECS;
		sod = secs % DAY_SECS;
		if (sod < 0) begin
			d -= 1;
			sod += DAY_SECS;
		end
		d += EPOCH_DAYS;
		if (d < 0)
			d = 0;
		y = d / 365;
		forever begin
			ys = y * 365 + leap_days_upto(y);
			if (d >= ys || y <= 0)
				break;
			y--;
		end
		if (d < ys)
			ys = 0;
		yd = d - ys;
		lp = is_leap(y);
		m = 11;
		while (m > 0 && yd < (lp ? CUM_LEAP[m] : CUM_COMMON[m]))
			m--;
		r.second      = 6'(sod % 60);
		r.minute      = 6'((sod / 60) % 60);
		r.hour        = 5'(sod / 3600);
		r.month_day   = 5'(yd - (lp ? CUM_LEAP[m] : CUM_COMMON[m]) + 1);
		r.month       = 4'(m);
		r.year        = 14'(y);
		r.week_day    = 3'((d + 6) % 7);
		r.year_day    = 9'(yd);
		r.millisecond = 10'((fr / 40500) % 1000);
		r.microsecond = 10'(((fr * 8) / 324) % 1000);
		return r;
	endfunction

	// ticks of a given day number (from year 0), second of day and fraction
	function automatic logic [63:0] ticks_of(longint dnum, longint sod, longint fr);
		return 64'(((dnum - EPOCH_DAYS) * DAY_SECS + sod) * TICK_HZ + fr);
	endfunction

	function automatic void cmp_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			n_errors++;
		end
	endfunction

	// transfer monitor and result checker
	always @(posedge clk) begin
		cal_rec_t e;
		if (arst_n && start && !busy)
			pending_dates.push_back(predict_calendar(tick_count));
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				$error("result with no transfer outstanding");
				n_errors++;
			end else begin
				e = pending_dates.pop_front();
				n_checked++;
				cmp_field("second", e.second, second);
				cmp_field("minute", e.minute, minute);
				cmp_field("hour", e.hour, hour);
				cmp_field("month_day", e.month_day, month_day);
				cmp_field("month", e.month, month);
				cmp_field("year", e.year, year);
				cmp_field("week_day", e.week_day, week_day);
				cmp_field("year_day", e.year_day, year_day);
				cmp_field("millisecond", e.millisecond, millisecond);
				cmp_field("microsecond", e.microsecond, microsecond);
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("ticks_to_calendar_time regression: fail");
			$finish;
		end
	end

	task automatic send_ticks(logic [63:0] v);
		if (!no_gaps)
			while ($urandom_range(99) < 18)
				@(posedge clk);
		@(posedge clk);
		start <= 1'b1;
		tick_count <= v;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		start <= 1'b0;
		tick_count <= {$urandom, $urandom};
		n_sent++;
	endtask

	task automatic test_directed();
		send_ticks(64'd0);
		send_ticks(64'hFFFF_FFFF_FFFF_FFFF);
		send_ticks(MIN_TICKS);
		send_ticks(MIN_TICKS - 64'd1);
		send_ticks(64'h8000_0000_0000_0000);
		send_ticks(64'h7FFF_FFFF_FFFF_FFFF);
		send_ticks(64'h5555_5555_5555_5555);
		send_ticks(64'hAAAA_AAAA_AAAA_AAAA);
		send_ticks(TICK_HZ - 1);
		send_ticks(TICK_HZ);
		send_ticks(-TICK_HZ);
		send_ticks(ticks_of(EPOCH_DAYS + 59, 0, 0));          // 2000-02-29
		send_ticks(ticks_of(EPOCH_DAYS + 365, DAY_SECS - 1, TICK_HZ - 1));
		send_ticks(ticks_of(EPOCH_DAYS - 1, 43200, 324));
		send_ticks(ticks_of(59, 3600, 40500));                // year 0, Feb 29
		send_ticks(ticks_of(365, 0, 0));                      // year 0 is leap
		send_ticks(ticks_of(1900 * 365 + leap_days_upto(1900) + 59, 0, 0));
		send_ticks(ticks_of(2100 * 365 + leap_days_upto(2100) - 1, 86399, 0));
		send_ticks(ticks_of(2400 * 365 + leap_days_upto(2400) + 365, 0, 0));
	endtask

	task automatic test_year_edges(int n);
		longint y, ys;
		for (int i = 0; i < n; i++) begin
			y = $urandom_range(9200);
			ys = y * 365 + leap_days_upto(y);
			case ($urandom_range(3))
				0: ys += 0;
				1: ys -= 1;
				2: ys += is_leap(y) ? 59 + $urandom_range(1) : 58 + $urandom_range(1);
				default: ys += $urandom_range(365);
			endcase
			if (ys < 0)
				ys = 0;
			send_ticks(ticks_of(ys, $urandom_range(86399), $urandom_range(40499999)));
		end
	endtask

	task automatic test_random(int n);
		logic [63:0] v;
		for (int i = 0; i < n; i++) begin
			no_gaps = (i >= n / 3 && i < n / 3 + 150);
			case ($urandom_range(3))
				0: v = {$urandom, $urandom};
				1: v = ticks_of($urandom_range(3652424), $urandom_range(86399),
					$urandom_range(40499999));
				2: v = 64'(signed'({$urandom_range(1000), $urandom}) - 64'sd1000000);
				default: v = MIN_TICKS + 64'($urandom);
			endcase
			send_ticks(v);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		tick_count = '0;
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_cycles = 0;
		no_gaps = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_year_edges(300);
		test_random(1200);
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (pending_dates.size() != 0) begin
			$error("%0d results never arrived", pending_dates.size());
			n_errors++;
		end
		$display("Converted %0d tick counts (saturation, leap days, year edges, random);",
			n_sent);
		$display("%0d calendar records checked, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0)
			$display("ticks_to_calendar_time regression: pass");
		else
			$display("ticks_to_calendar_time regression: fail");
		$finish;
	end
endmodule
